// ===== src/msq_pkg.sv =====
// Package for the max-score selection queue.
// Holds command, status and sequencer state codes; no dependencies.
package msq_pkg;

  localparam int unsigned SCORE_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_SET_PRIO = 2'd1,
    CMD_DEQUEUE  = 2'd2,
    CMD_REMOVE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_e;

endpackage

// ===== src/msq_cell.sv =====
// One storage cell of the rotating entry ring.
// Holds one (score, code) entry and takes its neighbor's entry on each shift.
module msq_cell #(
  parameter int unsigned ENTRY_W = 48
) (
  input  logic               clk_i,
  input  logic               shift_i,
  input  logic [ENTRY_W-1:0] d_i,
  output logic [ENTRY_W-1:0] q_o
);

  logic [ENTRY_W-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== src/max_score_selection_queue.sv =====
// Max-score selection queue: a ring of DEPTH entry cells plus one priority code.
// Set-priority, priority dequeue, dequeue while empty, push while full and ignored
// removes go to the result register from idle; a push makes a write pass of the ring,
// a remove that finds nothing a scan pass, an entry dequeue or hit remove both passes.
// One item at a time; the ring turns one entry past the head cell per cycle in a pass.
// Reset clears entry count, priority valid and the invalid code; entries stay undefined.
module max_score_selection_queue #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned CODE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration: invalid code
  input  logic                                  cfg_we_i,
  input  logic [CODE_BITS-1:0]                  cfg_wdata_i,
  // input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata fields, low bit up: code, score (32, two's complement), zero pad
  input  logic [((CODE_BITS+msq_pkg::SCORE_W+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser fields, low bit up: cmd (2)
  input  logic [1:0]                            s_axis_tuser_i,
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata fields, low bit up: out_code, zero pad
  output logic [((CODE_BITS+7)/8)*8-1:0]        m_axis_tdata_o,
  // tuser fields, low bit up: out_valid, now_empty, status (2)
  output logic [3:0]                            m_axis_tuser_o
);

  import msq_pkg::*;

  localparam int unsigned ENTRY_W = CODE_BITS + SCORE_W;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned K_W     = $clog2(DEPTH);
  localparam int unsigned OUT_W   = ((CODE_BITS + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  cmd_e                      in_cmd;
  logic [CODE_BITS-1:0]      in_code;
  logic signed [SCORE_W-1:0] in_score;
  logic                      in_fire;

  assign in_cmd   = cmd_e'(s_axis_tuser_i);
  assign in_code  = s_axis_tdata_i[CODE_BITS-1:0];
  assign in_score = $signed(s_axis_tdata_i[CODE_BITS +: SCORE_W]);

  // ---------------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------------
  state_e                    state_q, state_d;
  logic [K_W-1:0]            k_q, k_d;           // ring position now in the head cell
  cmd_e                      op_q, op_d;
  logic [CODE_BITS-1:0]      code_q, code_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      pv_q, pv_d;         // priority code held
  logic [CODE_BITS-1:0]      pcode_q, pcode_d;
  logic [CODE_BITS-1:0]      inv_q, inv_d;       // invalid code register
  logic [K_W-1:0]            best_q, best_d;     // selected slot
  logic signed [SCORE_W-1:0] best_key_q, best_key_d;
  logic [CODE_BITS-1:0]      best_code_q, best_code_d;
  logic                      found_q, found_d;
  logic [ENTRY_W-1:0]        last_q, last_d;     // copy of the last live entry

  // result register
  logic                      m_valid_q, m_valid_d;
  logic [CODE_BITS-1:0]      res_code_q, res_code_d;
  logic                      res_valid_q, res_valid_d;
  logic                      res_empty_q, res_empty_d;
  status_e                   res_status_q, res_status_d;

  // ---------------------------------------------------------------------------
  // Entry ring: cell i takes cell i+1, the tail cell takes the head or a new entry
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] ring_q [DEPTH];
  logic [ENTRY_W-1:0] wrap_d;
  logic [ENTRY_W-1:0] wr_entry;
  logic [CNT_W-1:0]   target;
  logic               shift;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] cell_d;
    if (i == DEPTH - 1) begin : g_tail
      assign cell_d = wrap_d;
    end else begin : g_body
      assign cell_d = ring_q[i+1];
    end
    msq_cell #(
      .ENTRY_W (ENTRY_W)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .d_i     (cell_d),
      .q_o     (ring_q[i])
    );
  end

  logic [CODE_BITS-1:0]      head_code;
  logic signed [SCORE_W-1:0] head_score;
  logic [CNT_W-1:0]          k_ext;
  logic                      k_last;
  logic                      in_range;
  logic                      match_now;
  logic                      out_free;

  assign head_code  = ring_q[0][CODE_BITS-1:0];
  assign head_score = $signed(ring_q[0][ENTRY_W-1:CODE_BITS]);
  assign k_ext      = CNT_W'(k_q);
  assign k_last     = (k_q == K_W'(DEPTH - 1));
  assign in_range   = (k_ext < count_q);
  assign shift      = (state_q != S_IDLE);

  // pushes write at the fill count; dequeue and remove refill the chosen slot
  assign wr_entry = (op_q == CMD_PUSH) ? {score_q, code_q} : last_q;
  assign target   = (op_q == CMD_PUSH) ? count_q : CNT_W'(best_q);
  assign wrap_d   = (state_q == S_WRITE && k_ext == target) ? wr_entry : ring_q[0];

  assign match_now = (state_q == S_SCAN) && in_range && (op_q == CMD_REMOVE)
                     && !found_q && (head_code == code_q);

  // a transfer in is taken only when idle and the result slot frees up
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_PUSH: begin
              if (count_q != CNT_W'(DEPTH)) state_d = S_WRITE;
            end
            CMD_DEQUEUE: begin
              if (!pv_q && count_q != '0) state_d = S_SCAN;
            end
            CMD_REMOVE: begin
              if (in_code != inv_q && count_q != '0) state_d = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (k_last) begin
          state_d = (op_q == CMD_DEQUEUE || found_q || match_now) ? S_WRITE : S_IDLE;
        end
      end
      S_WRITE: begin
        if (k_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and results
  // ---------------------------------------------------------------------------
  always_comb begin
    k_d          = k_q;
    op_d         = op_q;
    code_d       = code_q;
    score_d      = score_q;
    count_d      = count_q;
    pv_d         = pv_q;
    pcode_d      = pcode_q;
    inv_d        = cfg_we_i ? cfg_wdata_i : inv_q;
    best_d       = best_q;
    best_key_d   = best_key_q;
    best_code_d  = best_code_q;
    found_d      = found_q;
    last_d       = last_q;
    m_valid_d    = m_axis_tready_i ? 1'b0 : m_valid_q;
    res_code_d   = res_code_q;
    res_valid_d  = res_valid_q;
    res_empty_d  = res_empty_q;
    res_status_d = res_status_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_cmd;
          code_d  = in_code;
          score_d = in_score;
          k_d     = '0;
          found_d = 1'b0;
          // default: finish at once with nothing dequeued
          res_code_d   = inv_q;
          res_valid_d  = 1'b0;
          res_status_d = STAT_OK;
          res_empty_d  = !pv_q && (count_q == '0);
          case (in_cmd)
            CMD_PUSH: begin
              if (count_q == CNT_W'(DEPTH)) begin
                m_valid_d    = 1'b1;
                res_status_d = STAT_FULL;
              end
            end
            CMD_SET_PRIO: begin
              pcode_d     = in_code;
              pv_d        = (in_code != inv_q);
              m_valid_d   = 1'b1;
              res_empty_d = (in_code == inv_q) && (count_q == '0);
            end
            CMD_DEQUEUE: begin
              if (pv_q) begin
                // serve the priority code first and drop it
                pv_d        = 1'b0;
                m_valid_d   = 1'b1;
                res_code_d  = pcode_q;
                res_valid_d = 1'b1;
                res_empty_d = (count_q == '0);
              end else if (count_q == '0) begin
                m_valid_d    = 1'b1;
                res_status_d = STAT_EMPTY;
              end
            end
            CMD_REMOVE: begin
              if (in_code == inv_q || count_q == '0) m_valid_d = 1'b1;
            end
            default: m_valid_d = 1'b1;
          endcase
        end
      end

      S_SCAN: begin
        k_d = k_last ? '0 : k_q + 1'b1;
        if (in_range) begin
          if (op_q == CMD_DEQUEUE && (k_q == '0 || head_score > best_key_q)) begin
            // strictly greater keeps the first slot holding the maximum
            best_d      = k_q;
            best_key_d  = head_score;
            best_code_d = head_code;
          end
          if (match_now) begin
            found_d = 1'b1;
            best_d  = k_q;
          end
          if (k_ext + 1'b1 == count_q) last_d = ring_q[0];
        end
        if (k_last && op_q == CMD_REMOVE && !found_q && !match_now) begin
          m_valid_d    = 1'b1;
          res_code_d   = inv_q;
          res_valid_d  = 1'b0;
          res_status_d = STAT_OK;
          res_empty_d  = !pv_q && (count_q == '0);
        end
      end

      S_WRITE: begin
        k_d = k_last ? '0 : k_q + 1'b1;
        if (k_last) begin
          count_d      = (op_q == CMD_PUSH) ? count_q + 1'b1 : count_q - 1'b1;
          m_valid_d    = 1'b1;
          res_code_d   = (op_q == CMD_DEQUEUE) ? best_code_q : inv_q;
          res_valid_d  = (op_q == CMD_DEQUEUE);
          res_status_d = STAT_OK;
          res_empty_d  = !pv_q && (count_d == '0);
        end
      end

      default: k_d = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      count_q   <= '0;
      pv_q      <= 1'b0;
      inv_q     <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      count_q   <= count_d;
      pv_q      <= pv_d;
      inv_q     <= inv_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    code_q       <= code_d;
    score_q      <= score_d;
    pcode_q      <= pcode_d;
    best_q       <= best_d;
    best_key_q   <= best_key_d;
    best_code_q  <= best_code_d;
    last_q       <= last_d;
    res_code_q   <= res_code_d;
    res_valid_q  <= res_valid_d;
    res_empty_q  <= res_empty_d;
    res_status_q <= res_status_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_W'(res_code_q);
  assign m_axis_tuser_o  = {res_status_q, res_empty_q, res_valid_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_scan_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(count_q))
    else $error("entry count changed during scan");

  a_dequeue_scan_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && k_last && op_q == CMD_DEQUEUE) |=> (state_q == S_WRITE))
    else $error("dequeue scan did not refill the slot");

  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !k_last) |=> !$rose(m_valid_q))
    else $error("result raised in mid scan");

endmodule

// ===== bench/tb_max_score_selection_queue.sv =====
// Self-checking bench for max_score_selection_queue: drives command transfers,
// predicts each result from its own copy of the queue or takes it from a typed row, compares field by field.
// Depends on msq_pkg (cmd_e, status_e, SCORE_W) and the block itself.
`timescale 1ns / 100ps

module tb_max_score_selection_queue;
  import msq_pkg::*;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned CODE_BITS = 16;
  // Slowest items are entry dequeues and hit removes: a scan pass then a write pass. About
  // 1250 items at that cost, plus sender gaps, receiver stalls and the long hold, stay far below this.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 valid;
    logic                 empty;
    status_e              status;
  } result_t;

  typedef struct {
    cmd_e                 cmd;
    logic [CODE_BITS-1:0] code;
    logic [SCORE_W-1:0]   score;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CODE_BITS-1:0] cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // code (16), score (32, two's complement)
  logic [47:0]          s_axis_tdata_i  = '0;
  // cmd (2)
  logic [1:0]           s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // out_code (16)
  logic [15:0]          m_axis_tdata_o;
  // out_valid, now_empty, status (2)
  logic [3:0]           m_axis_tuser_o;

  max_score_selection_queue #(
    .DEPTH     (DEPTH),
    .CODE_BITS (CODE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the queue, updated in transfer order on the input side.
  logic [CODE_BITS-1:0]      held_code [DEPTH];
  logic signed [SCORE_W-1:0] held_score[DEPTH];
  int                        held_count = 0;
  logic [CODE_BITS-1:0]      prio_code  = '0;
  bit                        prio_valid = 1'b0;
  logic [CODE_BITS-1:0]      inv_code   = '0;

  result_t   queued_results[$];
  stim_row_t directed_rows[$];
  int        error_count  = 0;
  int        cycle_count  = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  bit        hold_armed   = 1'b0;

  // Close a slot by moving the last held entry into it.
  task automatic refill_slot(input int slot);
    held_count--;
    held_code[slot]  = held_code[held_count];
    held_score[slot] = held_score[held_count];
  endtask

  // Apply one command to the shadow queue and return the result it must produce.
  task automatic apply_command(input cmd_e cmd, input logic [CODE_BITS-1:0] code,
                               input logic signed [SCORE_W-1:0] score,
                               output result_t r);
    int  best;
    int  idx;
    bit  found;
    r.code   = inv_code;
    r.valid  = 1'b0;
    r.status = STAT_OK;
    case (cmd)
      CMD_PUSH: begin
        if (held_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          held_code[held_count]  = code;
          held_score[held_count] = score;
          held_count++;
        end
      end
      CMD_SET_PRIO: begin
        prio_code  = code;
        prio_valid = (code != inv_code);
      end
      CMD_DEQUEUE: begin
        if (prio_valid) begin
          r.code     = prio_code;
          r.valid    = 1'b1;
          prio_valid = 1'b0;
          prio_code  = inv_code;
        end else if (held_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // first entry with the strictly highest score wins, floor is entry zero
          best = 0;
          for (idx = 1; idx < held_count; idx++) begin
            if (held_score[idx] > held_score[best]) best = idx;
          end
          r.code  = held_code[best];
          r.valid = 1'b1;
          refill_slot(best);
        end
      end
      default: begin
        // removal of the invalid code is ignored; otherwise drop the first match
        found = 1'b0;
        if (code != inv_code) begin
          for (idx = 0; idx < held_count && !found; idx++) begin
            if (held_code[idx] == code) begin
              found = 1'b1;
              refill_slot(idx);
            end
          end
        end
      end
    endcase
    r.empty = !prio_valid && (held_count == 0);
  endtask

  function automatic stim_row_t mk_row(input cmd_e cmd, input logic [CODE_BITS-1:0] code,
                                       input logic [SCORE_W-1:0] score);
    stim_row_t row;
    row.cmd   = cmd;
    row.code  = code;
    row.score = score;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_typed(input cmd_e cmd, input logic [CODE_BITS-1:0] code,
                                         input logic [CODE_BITS-1:0] out_code,
                                         input logic valid, input logic empty,
                                         input status_e status);
    stim_row_t row;
    row = mk_row(cmd, code, '0);
    row.typed       = 1'b1;
    row.want.code   = out_code;
    row.want.valid  = valid;
    row.want.empty  = empty;
    row.want.status = status;
    return row;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Mostly a small pool so removes hit, sometimes the invalid code, sometimes anything.
  function automatic logic [CODE_BITS-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return inv_code;
    if (sel <= 2) return CODE_BITS'($urandom);
    return CODE_BITS'($urandom_range(0, 15));
  endfunction

  // Small scores give many ties; keep the full pattern inside the legal range.
  function automatic logic [SCORE_W-1:0] pick_score();
    int          sel;
    logic [31:0] raw;
    sel = $urandom_range(0, 9);
    if (sel <= 4) return SCORE_W'($urandom_range(0, 16) - 8);
    if (sel <= 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0001;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    raw = $urandom;
    if (raw == 32'h8000_0000) raw = 32'h8000_0001;
    return raw;
  endfunction

  // Offer one item, hold it until transfer, then record what must come back.
  task automatic send_item(input stim_row_t row);
    result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {row.score, row.code};
    s_axis_tuser_i  <= row.cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_command(row.cmd, row.code, row.score, predicted);
    queued_results.insert(queued_results.size(), row.typed ? row.want : predicted);
  endtask

  task automatic send_random();
    int   pick;
    cmd_e cmd;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = CMD_PUSH;
    else if (pick < 70) cmd = CMD_DEQUEUE;
    else if (pick < 88) cmd = CMD_REMOVE;
    else                cmd = CMD_SET_PRIO;
    send_item(mk_row(cmd, pick_code(), pick_score()));
  endtask

  // Stop offering, wait for every result, then give the block time to go quiet.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (queued_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the invalid code only while the block is idle.
  task automatic write_invalid_code(input logic [CODE_BITS-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    inv_code = value;
  endtask

  // Result side: check each transfer against the oldest prediction, then
  // decide tready for the next edge. The long hold-off is counted here.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (queued_results.size() == 0) begin
        $error("result transfer with nothing expected: code %h user %b",
               m_axis_tdata_o, m_axis_tuser_o);
        error_count++;
      end else begin
        want = queued_results.pop_front();
        if (m_axis_tdata_o[CODE_BITS-1:0] !== want.code) begin
          $error("out_code: expected %h, actual %h", want.code, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tuser_o[0] !== want.valid) begin
          $error("out_valid: expected %b, actual %b", want.valid, m_axis_tuser_o[0]);
          error_count++;
        end
        if (m_axis_tuser_o[1] !== want.empty) begin
          $error("now_empty: expected %b, actual %b", want.empty, m_axis_tuser_o[1]);
          error_count++;
        end
        if (m_axis_tuser_o[3:2] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser_o[3:2]);
          error_count++;
        end
      end
    end
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Watchdog: end the run if the queue hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_max_score_selection_queue: errors");
      $finish;
    end
  end

  initial begin
    // Directed part, run with the reset invalid code of zero. Typed rows can be
    // read straight off the spec; all others go through the shadow queue.
    add_row(mk_typed(CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, 1'b1, STAT_EMPTY));
    add_row(mk_typed(CMD_REMOVE, 16'h0005, 16'h0000, 1'b0, 1'b1, STAT_OK));
    // priority set to the invalid code holds nothing
    add_row(mk_typed(CMD_SET_PRIO, 16'h0000, 16'h0000, 1'b0, 1'b1, STAT_OK));
    add_row(mk_typed(CMD_SET_PRIO, 16'hFFFF, 16'h0000, 1'b0, 1'b0, STAT_OK));
    add_row(mk_typed(CMD_DEQUEUE, 16'h0000, 16'hFFFF, 1'b1, 1'b1, STAT_OK));
    // equal scores at the bottom of the range: first stored wins
    add_row(mk_row(CMD_PUSH, 16'h1234, 32'h8000_0001));
    add_row(mk_row(CMD_PUSH, 16'h0001, 32'h8000_0001));
    add_row(mk_row(CMD_DEQUEUE, 16'h0000, 32'h0));
    add_row(mk_row(CMD_PUSH, 16'hFFFF, 32'h7FFF_FFFF));
    add_row(mk_row(CMD_PUSH, 16'h0002, 32'h7FFF_FFFF));
    add_row(mk_row(CMD_PUSH, 16'h0003, 32'h0000_0000));
    // a second priority overwrites the first
    add_row(mk_row(CMD_SET_PRIO, 16'h0ABC, 32'hFFFF_FFFF));
    add_row(mk_row(CMD_SET_PRIO, 16'h0DEF, 32'h0));
    add_row(mk_row(CMD_DEQUEUE, 16'h0000, 32'h0));
    add_row(mk_row(CMD_DEQUEUE, 16'h0000, 32'h0));
    // removal of the invalid code is ignored even when it is held
    add_row(mk_row(CMD_PUSH, 16'h0000, 32'h0000_0005));
    add_row(mk_row(CMD_REMOVE, 16'h0000, 32'h0));
    add_row(mk_row(CMD_REMOVE, 16'h0003, 32'h0));
    // removal of a code not held changes nothing
    add_row(mk_row(CMD_REMOVE, 16'h7777, 32'h0));
    add_row(mk_row(CMD_DEQUEUE, 16'h0000, 32'h0));
    add_row(mk_row(CMD_DEQUEUE, 16'h0000, 32'h0));
    add_row(mk_row(CMD_DEQUEUE, 16'h0000, 32'h0));
    add_row(mk_typed(CMD_DEQUEUE, 16'h0000, 16'h0000, 1'b0, 1'b1, STAT_EMPTY));

    // Hold reset, then release it on an edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 29;
    snk_idle_pct = 49;
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Phase one: top invalid code, fill past full so pushes drop, drain past empty.
    write_invalid_code(16'hFFFF);
    repeat (DEPTH + 4) send_item(mk_row(CMD_PUSH, pick_code(), pick_score()));
    repeat (DEPTH + 6) send_item(mk_row(CMD_DEQUEUE, pick_code(), pick_score()));
    repeat (150) send_random();

    // Phase two: swap the idle rates, random invalid code.
    write_invalid_code(CODE_BITS'($urandom));
    src_idle_pct = 49;
    snk_idle_pct = 29;
    repeat (250) send_random();

    // Phase three: no idling, invalid code inside the code pool, and one long
    // receiver hold-off so the input side backs up.
    write_invalid_code(16'h0005);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_armed   = 1'b1;
    repeat (200) send_random();

    // Back to the reset invalid code for a short final stretch.
    write_invalid_code(16'h0000);
    repeat (100) send_random();

    settle();
    if (error_count == 0) begin
      $display("tb_max_score_selection_queue: clean");
    end else begin
      $display("tb_max_score_selection_queue: errors");
    end
    $finish;
  end

endmodule

// ===== max_score_selection_queue.f =====
src/msq_pkg.sv
src/msq_cell.sv
src/max_score_selection_queue.sv
bench/tb_max_score_selection_queue.sv
